// File: rtl/fmtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmtc_pkg
// Shared types, codes and constants of the floppy motor timeout control.
// ----------------------------------------------------------------------------
package fmtc_pkg;

  // Request codes as they arrive on the input channel
  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_MOTOR_ON  = 3'd1,
    OP_OFF_REQ   = 3'd2,
    OP_OFF_NOW   = 3'd3,
    OP_SELECT    = 3'd4,
    OP_RESET     = 3'd5,
    OP_ENABLE    = 3'd6
  } op_e;

  // Configuration register indexes
  localparam logic CFG_MOTOR_OFF_DELAY = 1'b0;
  localparam logic CFG_TICK_PRESCALE   = 1'b1;

  // Register reset values
  localparam logic [7:0] MOTOR_OFF_DELAY_RST = 8'd3;
  localparam logic [7:0] TICK_PRESCALE_RST   = 8'd16;

  // DOR constants
  localparam logic [7:0] DOR_RESET_VALUE  = 8'h0c;
  localparam logic [7:0] DOR_ENABLE_VALUE = 8'h1c;
  localparam logic [7:0] DOR_OFF_VALUE    = 8'h00;
  localparam logic [7:0] SELECT_KEEP_MASK = 8'hfc;
  localparam logic [7:0] MOTOR_KEEP_LOW   = 8'h0f;

  // Command queue depth between front and back
  localparam int QUEUE_DEPTH = 2;

  // Classified command
  typedef struct packed {
    op_e        op;
    logic [1:0] unit;
  } cmd_t;

  // Front to queue: one classified beat
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_enq_t;

  // Motor enable bit of a drive in the DOR
  function automatic logic [7:0] motor_bit(logic [1:0] unit);
    return 8'b0001_0000 << unit;
  endfunction

  // Shadow with one motor bit cleared
  function automatic logic [7:0] motor_clear(logic [7:0] dor, logic [1:0] unit);
    return dor & (~motor_bit(unit) | MOTOR_KEEP_LOW);
  endfunction

endpackage

// File: rtl/fmtc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmtc_front
// Accepts request beats, drops unused codes and out-of-range drives, and
// hands classified commands to the command queue.
// ----------------------------------------------------------------------------
module fmtc_front #(
  parameter int NUM_DRIVES = 4
) (
  input  logic                [2:0] req_type_i,
  input  logic                [1:0] drive_unit_i,
  input  logic                      push_i,
  input  logic                      q_full_i,
  output logic                      full_o,
  output fmtc_pkg::cmd_enq_t        enq_o
);

  logic unit_ok;
  logic keep;

  // Backpressure comes straight from the queue
  assign full_o  = q_full_i;
  assign unit_ok = (32'(drive_unit_i) < NUM_DRIVES);

  // Classify: drop the unused code and drive requests beyond the last drive
  always_comb begin
    keep = 1'b0;
    unique case (req_type_i)
      3'(fmtc_pkg::OP_TICK),
      3'(fmtc_pkg::OP_RESET),
      3'(fmtc_pkg::OP_ENABLE):     keep = 1'b1;
      3'(fmtc_pkg::OP_MOTOR_ON),
      3'(fmtc_pkg::OP_OFF_REQ),
      3'(fmtc_pkg::OP_OFF_NOW),
      3'(fmtc_pkg::OP_SELECT):     keep = unit_ok;
      default:                     keep = 1'b0;
    endcase
  end

  assign enq_o.valid    = push_i && !q_full_i && keep;
  assign enq_o.cmd.op   = fmtc_pkg::op_e'(req_type_i);
  assign enq_o.cmd.unit = drive_unit_i;

endmodule

// File: rtl/fmtc_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmtc_cmd_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module fmtc_cmd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fmtc_pkg::cmd_enq_t  enq_i,
  input  logic                deq_i,
  output logic                full_o,
  output logic                valid_o,
  output fmtc_pkg::cmd_t      cmd_o
);

  localparam int Depth = fmtc_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  fmtc_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_wr   = enq_i.valid && !full_o;
  assign do_rd   = deq_i && valid_o;

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= enq_i.cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (32'(wr_ptr_q) == Depth - 1) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (32'(rd_ptr_q) == Depth - 1) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// File: rtl/fmtc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmtc_back
// Executes commands: keeps the DOR shadow, motor-off countdowns, request
// flags and tick prescaler; emits DOR write beats via an output register.
// A tick's motor-off writes drain one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module fmtc_back #(
  parameter int NUM_DRIVES = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic          [7:0] cfg_wdata_i,
  input  logic                cmd_valid_i,
  input  fmtc_pkg::cmd_t      cmd_i,
  output logic                cmd_deq_o,
  input  logic                pop_i,
  output logic                empty_o,
  output logic          [7:0] dor_value_o,
  output logic                spin_up_o,
  output logic                last_o
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic                  state_q, state_d;
  logic            [7:0] delay_q, prescale_q;
  logic            [7:0] dor_q, dor_d;
  logic            [7:0] presc_q, presc_d;
  logic            [7:0] cnt_q [NUM_DRIVES];
  logic            [7:0] cnt_d [NUM_DRIVES];
  logic [NUM_DRIVES-1:0] offreq_q, offreq_d;
  logic [NUM_DRIVES-1:0] mask_q, mask_d;
  logic                  out_valid_q, out_valid_d;
  logic            [7:0] out_dor_q, out_dor_d;
  logic                  out_spin_q, out_spin_d;
  logic                  out_last_q, out_last_d;
  logic                  out_free;
  logic                  found;

  assign empty_o     = !out_valid_q;
  assign dor_value_o = out_dor_q;
  assign spin_up_o   = out_spin_q;
  assign last_o      = out_last_q;
  assign out_free    = !out_valid_q || pop_i;

  // Command execution and drain sequencing
  always_comb begin
    state_d     = state_q;
    dor_d       = dor_q;
    presc_d     = presc_q;
    cnt_d       = cnt_q;
    offreq_d    = offreq_q;
    mask_d      = mask_q;
    out_valid_d = out_valid_q && !pop_i;
    out_dor_d   = out_dor_q;
    out_spin_d  = out_spin_q;
    out_last_d  = out_last_q;
    cmd_deq_o   = 1'b0;
    found       = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_deq_o  = 1'b1;
          out_spin_d = 1'b0;
          out_last_d = 1'b1;
          unique case (cmd_i.op)
            fmtc_pkg::OP_TICK: begin
              if (presc_q == 8'd0) begin
                // Handled tick: count all flagged drives down at once
                presc_d = prescale_q;
                mask_d  = '0;
                for (int d = 0; d < NUM_DRIVES; d++) begin
                  if (offreq_q[d] && cnt_q[d] != 8'd0) begin
                    cnt_d[d] = cnt_q[d] - 8'd1;
                    if (cnt_q[d] == 8'd1) begin
                      mask_d[d] = 1'b1;
                    end
                  end
                end
                if (mask_d != '0) begin
                  state_d = ST_DRAIN;
                end
              end else begin
                presc_d = presc_q - 8'd1;
              end
            end
            fmtc_pkg::OP_MOTOR_ON: begin
              for (int d = 0; d < NUM_DRIVES; d++) begin
                if (cmd_i.unit == 2'(d)) begin
                  if (cnt_q[d] == 8'd0) begin
                    dor_d       = dor_q | fmtc_pkg::motor_bit(cmd_i.unit);
                    out_valid_d = 1'b1;
                    out_dor_d   = dor_d;
                    out_spin_d  = 1'b1;
                  end
                  offreq_d[d] = 1'b0;
                  cnt_d[d]    = delay_q;
                end
              end
            end
            fmtc_pkg::OP_OFF_REQ: begin
              for (int d = 0; d < NUM_DRIVES; d++) begin
                if (cmd_i.unit == 2'(d)) begin
                  offreq_d[d] = 1'b1;
                end
              end
            end
            fmtc_pkg::OP_OFF_NOW: begin
              dor_d       = fmtc_pkg::motor_clear(dor_q, cmd_i.unit);
              out_valid_d = 1'b1;
              out_dor_d   = dor_d;
            end
            fmtc_pkg::OP_SELECT: begin
              out_valid_d = 1'b1;
              out_dor_d   = (dor_q & fmtc_pkg::SELECT_KEEP_MASK) | {6'd0, cmd_i.unit};
            end
            fmtc_pkg::OP_RESET: begin
              dor_d       = fmtc_pkg::DOR_OFF_VALUE;
              out_valid_d = 1'b1;
              out_dor_d   = fmtc_pkg::DOR_OFF_VALUE;
            end
            fmtc_pkg::OP_ENABLE: begin
              dor_d       = fmtc_pkg::DOR_ENABLE_VALUE;
              out_valid_d = 1'b1;
              out_dor_d   = fmtc_pkg::DOR_ENABLE_VALUE;
            end
            default: begin
              cmd_deq_o = 1'b1;
            end
          endcase
        end
      end
      ST_DRAIN: begin
        // Switch off the lowest expired drive, one write per beat
        if (out_free) begin
          for (int d = 0; d < NUM_DRIVES; d++) begin
            if (!found && mask_q[d]) begin
              found     = 1'b1;
              mask_d[d] = 1'b0;
              dor_d     = fmtc_pkg::motor_clear(dor_q, 2'(d));
            end
          end
          out_valid_d = 1'b1;
          out_dor_d   = dor_d;
          out_spin_d  = 1'b0;
          out_last_d  = (mask_d == '0);
          if (mask_d == '0) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q    <= fmtc_pkg::MOTOR_OFF_DELAY_RST;
      prescale_q <= fmtc_pkg::TICK_PRESCALE_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == fmtc_pkg::CFG_MOTOR_OFF_DELAY) begin
        delay_q <= cfg_wdata_i;
      end else if (cfg_idx_i == fmtc_pkg::CFG_TICK_PRESCALE) begin
        prescale_q <= cfg_wdata_i;
      end
    end
  end

  // Control state and timers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dor_q       <= fmtc_pkg::DOR_RESET_VALUE;
      presc_q     <= 8'd0;
      offreq_q    <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
      for (int d = 0; d < NUM_DRIVES; d++) begin
        cnt_q[d] <= 8'd0;
      end
    end else begin
      state_q     <= state_d;
      dor_q       <= dor_d;
      presc_q     <= presc_d;
      offreq_q    <= offreq_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Output beat payload
  always_ff @(posedge clk_i) begin
    out_dor_q  <= out_dor_d;
    out_spin_q <= out_spin_d;
    out_last_q <= out_last_d;
  end

endmodule

// File: rtl/floppy_motor_timeout_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// floppy_motor_timeout_control
// Floppy DOR shadow with per-drive motor-off timers.
// ----------------------------------------------------------------------------
// Input channel: push with req_type_i/drive_unit_i; a beat is taken when
// push is high and full is low. Unused codes and drives beyond
// NUM_DRIVES are taken and dropped.
// Result channel: while empty is low the oldest DOR write sits on
// dor_value_o/spin_up_o/last_o; pop takes it.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 motor-off delay, 1 tick prescale). The user writes only while idle;
// the block itself does not enforce it. An accepted request is stored in
// the command queue, and its DOR write, if any, in the output register.
// Throughput: one request per cycle while full is low; after a handled tick
// the back end drains one motor-off write per expiring drive, one at a time
// through its single output register. A two-entry command queue lets the
// front keep accepting while the back waits.
// When the receiver stalls, the output register holds, the back stops, the
// queue fills and full rises. Reset loads DOR shadow 0x0c, clears timers,
// flags and prescaler, and restores the register defaults.
// ----------------------------------------------------------------------------
module floppy_motor_timeout_control #(
  parameter int NUM_DRIVES = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  logic [2:0] req_type_i,
  input  logic [1:0] drive_unit_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] dor_value_o,
  output logic       spin_up_o,
  output logic       last_o
);

  fmtc_pkg::cmd_enq_t enq;
  fmtc_pkg::cmd_t     q_cmd;
  logic               q_full;
  logic               q_valid;
  logic               q_deq;

  // Classify incoming beats
  fmtc_front #(
    .NUM_DRIVES (NUM_DRIVES)
  ) u_front (
    .req_type_i   (req_type_i),
    .drive_unit_i (drive_unit_i),
    .push_i       (push),
    .q_full_i     (q_full),
    .full_o       (full),
    .enq_o        (enq)
  );

  // Buffer commands between front and back
  fmtc_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .enq_i   (enq),
    .deq_i   (q_deq),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  // Execute commands and emit DOR writes
  fmtc_back #(
    .NUM_DRIVES (NUM_DRIVES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_deq_o   (q_deq),
    .pop_i       (pop),
    .empty_o     (empty),
    .dor_value_o (dor_value_o),
    .spin_up_o   (spin_up_o),
    .last_o      (last_o)
  );

endmodule
